/* rtl/core/llca_pkg.sv */
// ----------------------------------------------------------------------------
// llca_pkg
// Shared constants, register indexes and controller/datapath link types
// for the least-loaded core allocator.
// ----------------------------------------------------------------------------
package llca_pkg;

    localparam int DEF_MAX_CORES = 16;
    localparam int DEF_MAX_LOAD  = 127;

    localparam int LOAD_W     = 7;
    localparam int ACTIVE_W   = 5;
    localparam int WORD_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_IDX_W  = 4;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;

    // remainder unit works on the low 31 bits of the draw
    localparam int DIV_STEPS = 31;
    localparam int DIVCNT_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_W = 3'd4;

    localparam logic [ACTIVE_W-1:0] RST_ACTIVE = 5'd16;
    localparam logic [WORD_W-1:0]   RST_SEED_X = 32'd123459876;
    localparam logic [WORD_W-1:0]   RST_SEED_Y = 32'd362436069;
    localparam logic [WORD_W-1:0]   RST_SEED_Z = 32'd521288629;
    localparam logic [WORD_W-1:0]   RST_SEED_W = 32'd88675123;

    localparam int SHL_T = 11;
    localparam int SHR_W = 19;
    localparam int SHR_T = 8;

    typedef struct packed {
        logic load_req;   // capture request, reset scan and min/tie trackers
        logic scan_min;   // min/tie pass over load store
        logic scan_sel;   // selection pass over load store
        logic draw;       // advance generator, start remainder
        logic div_step;   // one remainder step
        logic update;     // write back load and occupied mark
        logic out_load;   // load result register
    } llca_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic ties_zero;
        logic div_done;
    } llca_status_t;

endpackage

/* rtl/core/least_loaded_core_allocator.sv */
// ----------------------------------------------------------------------------
// least_loaded_core_allocator
// Picks a random core among the least-loaded free cores for each request.
// ----------------------------------------------------------------------------
// One request is handled at a time. For a request that finds a free core,
// the block takes the request, makes a first pass over the load store of
// the enabled cores, draws, runs a 31-step bit-serial remainder of the
// random draw by the tie count, makes a second pass to pick the core,
// updates its load and hands over the result. Each pass reads one entry
// per cycle through the single read port of the load store. A request
// that finds no free core skips the draw, the remainder, the second pass
// and the update.
// The result sits in an output register, so a new request is taken while
// the previous result still waits. The next result then holds the block
// until m_axis_tready frees the register. Load counts and occupied marks are
// clear right after reset; no clearing pass is needed.
module least_loaded_core_allocator
#(
    parameter int MAX_CORES = llca_pkg::DEF_MAX_CORES,
    parameter int MAX_LOAD  = llca_pkg::DEF_MAX_LOAD
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [llca_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [llca_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [llca_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [0] occupy_core
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [llca_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [3:0] core_index
    output logic                                m_axis_tuser    // [0] found
);

    llca_pkg::llca_cmd_t    cmd;
    llca_pkg::llca_status_t status;
    logic [llca_pkg::OUT_IDX_W-1:0] core_index;

    llca_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    llca_dpath
    #(
        .MAX_CORES (MAX_CORES),
        .MAX_LOAD  (MAX_LOAD)
    )
    u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .occupy_core (s_axis_tdata[0]),
        .cmd         (cmd),
        .status      (status),
        .found       (m_axis_tuser),
        .core_index  (core_index)
    );

    assign m_axis_tdata = llca_pkg::OUT_TDATA_W'(core_index);

endmodule

/* rtl/core/llca_ctrl.sv */
// ----------------------------------------------------------------------------
// llca_ctrl
// Request sequencer: scan, draw, remainder, select, update, deliver.
// ----------------------------------------------------------------------------
module llca_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  llca_pkg::llca_status_t status,
    output llca_pkg::llca_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_DRAW = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SEL  = 3'd4;
    localparam logic [2:0] ST_UPD  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_min = 1'b1;
                if (status.scan_done)
                begin
                    state_next = status.ties_zero ? ST_FIN : ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                cmd.draw   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_SEL;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_SEL:
            begin
                cmd.scan_sel = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/core/llca_dpath.sv */
// ----------------------------------------------------------------------------
// llca_dpath
// Load store, occupied marks, xorshift128 generator, serial remainder
// and the scan logic that finds the least load and the chosen core.
// ----------------------------------------------------------------------------
module llca_dpath
#(
    parameter int MAX_CORES = llca_pkg::DEF_MAX_CORES,
    parameter int MAX_LOAD  = llca_pkg::DEF_MAX_LOAD
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [llca_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [llca_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               occupy_core,
    input  llca_pkg::llca_cmd_t                cmd,
    output llca_pkg::llca_status_t             status,
    output logic                               found,
    output logic [llca_pkg::OUT_IDX_W-1:0]     core_index
);

    localparam int IDX_W = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int CNT_W = $clog2(MAX_CORES + 1);
    localparam int LW    = llca_pkg::LOAD_W;
    localparam int WW    = llca_pkg::WORD_W;

    // configuration and generator
    logic [llca_pkg::ACTIVE_W-1:0] active_reg;
    logic [WW-1:0] rx_reg, ry_reg, rz_reg, rw_reg;
    logic [WW-1:0] t_val, w_new;

    // per-core state
    logic [LW-1:0]        load_mem [MAX_CORES];
    logic [MAX_CORES-1:0] lv_reg;
    logic [MAX_CORES-1:0] occ_reg;

    // scan
    logic [CNT_W-1:0] n_cores;
    logic [CNT_W-1:0] idx_reg;
    logic             pipe_v_reg;
    logic [IDX_W-1:0] pipe_idx_reg;
    logic [LW-1:0]    rd_data_reg;
    logic             scan_run;
    logic             issue;
    logic             elig;
    logic [LW-1:0]    load_q;

    logic [LW-1:0]    least_reg;
    logic [CNT_W-1:0] ties_reg;
    logic [CNT_W-1:0] seen_reg;
    logic [IDX_W-1:0] chosen_reg;
    logic [LW-1:0]    chosen_load_reg;
    logic             occupy_reg;

    // remainder
    logic [llca_pkg::DIV_STEPS-1:0] dividend_reg;
    logic [CNT_W-1:0]               rem_reg;
    logic [llca_pkg::DIVCNT_W-1:0]  div_cnt_reg;
    logic [CNT_W:0]                 rem_sh;
    logic                           rem_ge;

    logic             found_reg;
    logic [llca_pkg::OUT_IDX_W-1:0] core_index_reg;

    assign n_cores = (int'(active_reg) > MAX_CORES) ? CNT_W'(MAX_CORES) : CNT_W'(active_reg);

    assign t_val = rx_reg ^ (rx_reg << llca_pkg::SHL_T);
    assign w_new = (rw_reg ^ (rw_reg >> llca_pkg::SHR_W)) ^ (t_val ^ (t_val >> llca_pkg::SHR_T));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= llca_pkg::RST_ACTIVE;
            rx_reg     <= llca_pkg::RST_SEED_X;
            ry_reg     <= llca_pkg::RST_SEED_Y;
            rz_reg     <= llca_pkg::RST_SEED_Z;
            rw_reg     <= llca_pkg::RST_SEED_W;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                llca_pkg::CFG_ACTIVE: active_reg <= cfg_wdata[llca_pkg::ACTIVE_W-1:0];
                llca_pkg::CFG_SEED_X: rx_reg     <= cfg_wdata[WW-1:0];
                llca_pkg::CFG_SEED_Y: ry_reg     <= cfg_wdata[WW-1:0];
                llca_pkg::CFG_SEED_Z: rz_reg     <= cfg_wdata[WW-1:0];
                llca_pkg::CFG_SEED_W: rw_reg     <= cfg_wdata[WW-1:0];
                default:
                begin
                end
            endcase
        end
        else if (cmd.draw)
        begin
            rx_reg <= ry_reg;
            ry_reg <= rz_reg;
            rz_reg <= rw_reg;
            rw_reg <= w_new;
        end
    end

    // scan front end: one read per cycle, read data is registered
    assign scan_run = cmd.scan_min | cmd.scan_sel;
    assign issue    = scan_run && (idx_reg < n_cores);
    assign elig     = pipe_v_reg && !occ_reg[pipe_idx_reg];
    assign load_q   = lv_reg[pipe_idx_reg] ? rd_data_reg : '0;

    assign status.scan_done = scan_run && !issue && !pipe_v_reg;
    assign status.ties_zero = (ties_reg == '0);
    assign status.div_done  = (div_cnt_reg == llca_pkg::DIVCNT_W'(llca_pkg::DIV_STEPS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            pipe_v_reg <= 1'b0;
        end
        else if (cmd.load_req || cmd.draw)
        begin
            idx_reg    <= '0;
            pipe_v_reg <= 1'b0;
        end
        else if (scan_run)
        begin
            pipe_v_reg <= issue;
            if (issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg  <= load_mem[idx_reg[IDX_W-1:0]];
            pipe_idx_reg <= idx_reg[IDX_W-1:0];
        end
        if (cmd.update)
        begin
            load_mem[chosen_reg] <= (chosen_load_reg < LW'(MAX_LOAD))
                                    ? chosen_load_reg + 1'b1 : chosen_load_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lv_reg  <= '0;
            occ_reg <= '0;
        end
        else if (cmd.update)
        begin
            lv_reg[chosen_reg] <= 1'b1;
            if (occupy_reg && (n_cores > CNT_W'(1)))
            begin
                occ_reg[chosen_reg] <= 1'b1;
            end
        end
    end

    // min/tie tracking and tied-core selection
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            occupy_reg <= occupy_core;
            least_reg  <= LW'(MAX_LOAD);
            ties_reg   <= '0;
        end
        else if (cmd.scan_min && elig)
        begin
            if (load_q < least_reg)
            begin
                least_reg <= load_q;
                ties_reg  <= CNT_W'(1);
            end
            else if (load_q == least_reg)
            begin
                ties_reg <= ties_reg + 1'b1;
            end
        end

        if (cmd.draw)
        begin
            seen_reg <= '0;
        end
        else if (cmd.scan_sel && elig && (load_q == least_reg))
        begin
            if (seen_reg == rem_reg)
            begin
                chosen_reg      <= pipe_idx_reg;
                chosen_load_reg <= load_q;
            end
            seen_reg <= seen_reg + 1'b1;
        end
    end

    // restoring remainder, one dividend bit per step
    assign rem_sh = {rem_reg, dividend_reg[llca_pkg::DIV_STEPS-1]};
    assign rem_ge = (rem_sh >= {1'b0, ties_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.draw)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.draw)
        begin
            dividend_reg <= w_new[llca_pkg::DIV_STEPS-1:0];
            rem_reg      <= '0;
        end
        else if (cmd.div_step)
        begin
            dividend_reg <= {dividend_reg[llca_pkg::DIV_STEPS-2:0], 1'b0};
            rem_reg      <= rem_ge ? CNT_W'(rem_sh - {1'b0, ties_reg}) : rem_sh[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            found_reg      <= (ties_reg != '0);
            core_index_reg <= (ties_reg != '0) ? llca_pkg::OUT_IDX_W'(chosen_reg) : '0;
        end
    end

    assign found      = found_reg;
    assign core_index = core_index_reg;

endmodule
